// ===== design/dsst_pkg.sv =====
// ----------------------------------------------------------------------------
// dsst_pkg
// shared types, widths and codes of the daily schedule switch timer
// ----------------------------------------------------------------------------
package dsst_pkg;

  localparam int SLOTS    = 10;
  localparam int SWITCHES = 2;
  localparam int ENTRIES  = SLOTS * SWITCHES;

  localparam int ADDR_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int SW_W   = (SWITCHES > 1) ? $clog2(SWITCHES) : 1;

  localparam int TPS_W   = 10;
  localparam int HOUR_W  = 5;
  localparam int MIN_W   = 6;
  localparam int SEC_W   = 6;
  localparam int BYTE_W  = 8;
  localparam int ENTRY_W = 4 * BYTE_W;

  localparam logic [TPS_W-1:0]   TPS_RESET    = TPS_W'(1000);
  localparam logic [HOUR_W-1:0]  HOUR_MAX     = HOUR_W'(23);
  localparam logic [MIN_W-1:0]   MINUTE_MAX   = MIN_W'(59);
  localparam logic [SEC_W-1:0]   SECOND_MAX   = SEC_W'(59);
  localparam logic [ENTRY_W-1:0] SLOT_DISABLED = '1;

  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_SLOT  = 2'd1,
    CMD_TIME  = 2'd2,
    CMD_FORCE = 2'd3
  } cmd_t;

  // per-switch result of one schedule walk
  typedef struct packed {
    logic            valid;
    logic [SW_W-1:0] sw;
    logic            on_hit;
    logic            off_hit;
    logic            done;
  } hit_t;

endpackage

// ===== design/dsst_if.sv =====
// ----------------------------------------------------------------------------
// dsst_in_if / dsst_out_if
// valid/ready channels for command beats and result beats
// ----------------------------------------------------------------------------
interface dsst_in_if;
  import dsst_pkg::*;

  logic              valid;
  logic              ready;
  logic [1:0]        command;
  logic              switch_sel;
  logic [3:0]        slot;
  logic [BYTE_W-1:0] on_hour;
  logic [BYTE_W-1:0] on_minute;
  logic [BYTE_W-1:0] off_hour;
  logic [BYTE_W-1:0] off_minute;
  logic [HOUR_W-1:0] set_hour;
  logic [MIN_W-1:0]  set_minute;
  logic [SEC_W-1:0]  set_second;
  logic [1:0]        force_levels;

  modport source (
    output valid, command, switch_sel, slot, on_hour, on_minute, off_hour, off_minute,
           set_hour, set_minute, set_second, force_levels,
    input  ready
  );
  modport sink (
    input  valid, command, switch_sel, slot, on_hour, on_minute, off_hour, off_minute,
           set_hour, set_minute, set_second, force_levels,
    output ready
  );
endinterface

interface dsst_out_if;
  import dsst_pkg::*;

  logic              valid;
  logic              ready;
  logic [1:0]        switch_levels;
  logic              status_changed;
  logic [HOUR_W-1:0] clock_hour;
  logic [MIN_W-1:0]  clock_minute;
  logic [SEC_W-1:0]  clock_second;

  modport source (
    output valid, switch_levels, status_changed, clock_hour, clock_minute, clock_second,
    input  ready
  );
  modport sink (
    input  valid, switch_levels, status_changed, clock_hour, clock_minute, clock_second,
    output ready
  );
endinterface

// ===== design/dsst_sched_mem.sv =====
// ----------------------------------------------------------------------------
// dsst_sched_mem
// schedule slot memory, one write and one registered read port,
// per-entry valid bits so unwritten slots read as disabled
// ----------------------------------------------------------------------------
module dsst_sched_mem (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          wr_en,
  input  logic [dsst_pkg::ADDR_W-1:0]   wr_addr,
  input  logic [dsst_pkg::ENTRY_W-1:0]  wr_data,
  input  logic                          rd_en,
  input  logic [dsst_pkg::ADDR_W-1:0]   rd_addr,
  output logic [dsst_pkg::ENTRY_W-1:0]  rd_data
);
  import dsst_pkg::*;

  logic [ENTRY_W-1:0] mem [ENTRIES];
  logic [ENTRIES-1:0] vld_r;
  logic [ENTRY_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (wr_en) begin
      vld_r[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= vld_r[rd_addr] ? mem[rd_addr] : SLOT_DISABLED;
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== design/dsst_scan.sv =====
// ----------------------------------------------------------------------------
// dsst_scan
// schedule walker: reads one slot a cycle and matches it against the clock,
// reporting on/off hits at the end of each switch's slots
// ----------------------------------------------------------------------------
module dsst_scan (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [dsst_pkg::HOUR_W-1:0]   hour,
  input  logic [dsst_pkg::MIN_W-1:0]    minute,
  output logic                          rd_en,
  output logic [dsst_pkg::ADDR_W-1:0]   rd_addr,
  input  logic [dsst_pkg::ENTRY_W-1:0]  rd_data,
  output dsst_pkg::hit_t                hit
);
  import dsst_pkg::*;

  logic              issue_r;
  logic [ADDR_W-1:0] addr_r;
  logic [SLOT_W-1:0] slot_r;
  logic [SW_W-1:0]   sw_r;
  logic              pend_r;
  logic [SW_W-1:0]   pend_sw_r;
  logic              pend_last_r;
  logic              on_acc_r;
  logic              off_acc_r;

  logic              slot_end;
  logic              on_m;
  logic              off_m;
  logic [BYTE_W-1:0] hour_b;
  logic [BYTE_W-1:0] min_b;

  assign slot_end = (slot_r == SLOT_W'(SLOTS - 1));
  assign hour_b   = BYTE_W'(hour);
  assign min_b    = BYTE_W'(minute);

  // slot layout: on_hour, on_minute, off_hour, off_minute from msb down
  assign on_m  = (rd_data[31:24] == hour_b) && (rd_data[23:16] == min_b);
  assign off_m = (rd_data[15:8] == hour_b) && (rd_data[7:0] == min_b);

  assign rd_en   = issue_r;
  assign rd_addr = addr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      issue_r     <= 1'b0;
      pend_r      <= 1'b0;
      addr_r      <= '0;
      slot_r      <= '0;
      sw_r        <= '0;
      pend_sw_r   <= '0;
      pend_last_r <= 1'b0;
      on_acc_r    <= 1'b0;
      off_acc_r   <= 1'b0;
    end else begin
      pend_r <= issue_r;
      if (start) begin
        issue_r   <= 1'b1;
        addr_r    <= '0;
        slot_r    <= '0;
        sw_r      <= '0;
        on_acc_r  <= 1'b0;
        off_acc_r <= 1'b0;
      end else if (issue_r) begin
        pend_sw_r   <= sw_r;
        pend_last_r <= slot_end;
        addr_r      <= addr_r + ADDR_W'(1);
        if (slot_end) begin
          slot_r <= '0;
          sw_r   <= sw_r + SW_W'(1);
          if (sw_r == SW_W'(SWITCHES - 1)) begin
            issue_r <= 1'b0;
          end
        end else begin
          slot_r <= slot_r + SLOT_W'(1);
        end
      end
      if (pend_r) begin
        if (pend_last_r) begin
          on_acc_r  <= 1'b0;
          off_acc_r <= 1'b0;
        end else begin
          on_acc_r  <= on_acc_r | on_m;
          off_acc_r <= off_acc_r | off_m;
        end
      end
    end
  end

  always_comb begin
    hit.valid   = pend_r && pend_last_r;
    hit.sw      = pend_sw_r;
    hit.on_hit  = on_acc_r | on_m;
    hit.off_hit = off_acc_r | off_m;
    hit.done    = pend_r && pend_last_r && (pend_sw_r == SW_W'(SWITCHES - 1));
  end

endmodule

// ===== design/daily_schedule_switch_timer.sv =====
// ----------------------------------------------------------------------------
// daily_schedule_switch_timer
// sequencing: slot writes, time loads, forces and ticks that do
//   not finish a second go straight to the emit state; a tick that starts a
//   new second first runs the one-slot-per-cycle walk over the schedule memory
// handshake: no new beat while one is in work
// reset: synchronous active-low rst_n clears clock, prescaler and switches,
//   marks all slots disabled and loads 1000 ticks per second
// ----------------------------------------------------------------------------
module daily_schedule_switch_timer (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [dsst_pkg::TPS_W-1:0]  cfg_wdata,
  dsst_in_if.sink                     in_bus,
  dsst_out_if.source                  out_bus
);
  import dsst_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_EMIT = 3'b100
  } state_t;

  state_t state_r;

  logic [TPS_W-1:0]    tps_r;
  logic [TPS_W-1:0]    prescale_r;
  logic [HOUR_W-1:0]   hour_r;
  logic [MIN_W-1:0]    min_r;
  logic [SEC_W-1:0]    sec_r;
  logic [SWITCHES-1:0] sw_state_r;
  logic                changed_r;

  logic                out_valid_r;
  logic [1:0]          out_levels_r;
  logic                out_changed_r;
  logic [HOUR_W-1:0]   out_hour_r;
  logic [MIN_W-1:0]    out_min_r;
  logic [SEC_W-1:0]    out_sec_r;

  logic                accept;
  logic [TPS_W-1:0]    prescale_nxt;
  logic                new_second;
  logic [HOUR_W-1:0]   hour_nxt;
  logic [MIN_W-1:0]    min_nxt;
  logic [SEC_W-1:0]    sec_nxt;
  logic                slot_we;
  logic [ADDR_W-1:0]   slot_waddr;
  logic [ENTRY_W-1:0]  slot_wdata;
  logic                scan_start;
  logic                rd_en;
  logic [ADDR_W-1:0]   rd_addr;
  logic [ENTRY_W-1:0]  rd_data;
  hit_t                hit;
  logic                cur_bit;
  logic                mid_bit;
  logic                hit_chg;

  assign in_bus.ready = (state_r == ST_IDLE) && (!out_valid_r || out_bus.ready);
  assign accept       = in_bus.valid && in_bus.ready;

  assign prescale_nxt = prescale_r + TPS_W'(1);
  assign new_second   = (prescale_nxt >= tps_r) || (prescale_nxt == '0);

  // next second of the day
  always_comb begin
    hour_nxt = hour_r;
    min_nxt  = min_r;
    sec_nxt  = sec_r + SEC_W'(1);
    if (sec_r >= SECOND_MAX) begin
      sec_nxt = '0;
      min_nxt = min_r + MIN_W'(1);
      if (min_r >= MINUTE_MAX) begin
        min_nxt  = '0;
        hour_nxt = (hour_r >= HOUR_MAX) ? '0 : hour_r + HOUR_W'(1);
      end
    end
  end

  assign slot_we    = accept && (cmd_t'(in_bus.command) == CMD_SLOT)
                      && (32'(in_bus.switch_sel) < SWITCHES) && (32'(in_bus.slot) < SLOTS);
  assign slot_waddr = ADDR_W'(ADDR_W'(in_bus.switch_sel) * ADDR_W'(SLOTS))
                      + ADDR_W'(in_bus.slot);
  assign slot_wdata = {in_bus.on_hour, in_bus.on_minute, in_bus.off_hour, in_bus.off_minute};
  assign scan_start = accept && (cmd_t'(in_bus.command) == CMD_TICK) && new_second;

  dsst_sched_mem u_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (slot_we),
    .wr_addr (slot_waddr),
    .wr_data (slot_wdata),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  dsst_scan u_scan (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (scan_start),
    .hour    (hour_r),
    .minute  (min_r),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .hit     (hit)
  );

  // turn on first, then off, within the same second
  assign cur_bit = sw_state_r[hit.sw];
  assign mid_bit = cur_bit | hit.on_hit;
  assign hit_chg = (hit.on_hit && !cur_bit) || (hit.off_hit && mid_bit);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tps_r <= TPS_RESET;
    end else if (cfg_we) begin
      tps_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      prescale_r <= '0;
      hour_r     <= '0;
      min_r      <= '0;
      sec_r      <= '0;
      sw_state_r <= '0;
      changed_r  <= 1'b0;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          if (accept) begin
            changed_r <= 1'b0;
            state_r   <= ST_EMIT;
            case (cmd_t'(in_bus.command))
              CMD_TICK: begin
                if (new_second) begin
                  prescale_r <= '0;
                  hour_r     <= hour_nxt;
                  min_r      <= min_nxt;
                  sec_r      <= sec_nxt;
                  state_r    <= ST_SCAN;
                end else begin
                  prescale_r <= prescale_nxt;
                end
              end
              CMD_TIME: begin
                hour_r <= (in_bus.set_hour > HOUR_MAX) ? '0 : in_bus.set_hour;
                min_r  <= (in_bus.set_minute > MINUTE_MAX) ? '0 : in_bus.set_minute;
                sec_r  <= (in_bus.set_second > SECOND_MAX) ? '0 : in_bus.set_second;
              end
              CMD_FORCE: begin
                sw_state_r <= in_bus.force_levels[SWITCHES-1:0];
              end
              default: begin
              end
            endcase
          end
        end
        ST_SCAN: begin
          if (hit.valid) begin
            sw_state_r[hit.sw] <= mid_bit & ~hit.off_hit;
            if (hit_chg) begin
              changed_r <= 1'b1;
            end
          end
          if (hit.done) begin
            state_r <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          state_r <= ST_IDLE;
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  // result beat register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == ST_EMIT) begin
      out_valid_r <= 1'b1;
    end else if (out_bus.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_EMIT) begin
      out_levels_r  <= 2'(sw_state_r);
      out_changed_r <= changed_r;
      out_hour_r    <= hour_r;
      out_min_r     <= min_r;
      out_sec_r     <= sec_r;
    end
  end

  assign out_bus.valid          = out_valid_r;
  assign out_bus.switch_levels  = out_levels_r;
  assign out_bus.status_changed = out_changed_r;
  assign out_bus.clock_hour     = out_hour_r;
  assign out_bus.clock_minute   = out_min_r;
  assign out_bus.clock_second   = out_sec_r;

endmodule
